// ===== hdl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define REWB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define REWB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rewb_pkg.sv =====
package rewb_pkg;

	// request operation codes
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_FREAD  = 2'd2,
		OP_SREAD  = 2'd3
	} op_t;

	// reported switch state
	typedef enum logic [1:0] {
		SW_RELEASED      = 2'd0,
		SW_JUST_PRESSED  = 2'd1,
		SW_PRESSED       = 2'd2,
		SW_JUST_RELEASED = 2'd3
	} sw_state_t;

	// press/release machine, one-hot
	typedef enum logic [1:0] {
		STG_WAIT_PRESS   = 2'b01,
		STG_WAIT_RELEASE = 2'b10
	} stage_t;

	localparam int unsigned WIN_W = 16;
	localparam int unsigned CNT_W = 32;
	localparam logic [WIN_W-1:0] FILTER_RESET_MS = 16'd250;

	typedef struct packed {
		op_t  operation;
		logic phase_a;
		logic phase_b;
		logic switch_level;
	} item_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] count_delta;
		logic signed [CNT_W-1:0] raw_count;
		logic [1:0]              switch_state;
		logic [CNT_W-1:0]        pressed_ms;
	} result_t;

	// handshake between input register, engine and result register
	typedef struct packed {
		logic valid_s1;
		logic advance;
	} pipe_ctl_t;

endpackage

// ===== hdl/rewb_ifs.sv =====
// request channel
interface rewb_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic       phase_a;
	logic       phase_b;
	logic       switch_level;

	modport source (output valid, operation, phase_a, phase_b, switch_level, input ready);
	modport sink (input valid, operation, phase_a, phase_b, switch_level, output ready);
endinterface

// result channel
interface rewb_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] count_delta;
	logic signed [31:0] raw_count;
	logic [1:0]         switch_state;
	logic [31:0]        pressed_ms;

	modport source (output valid, count_delta, raw_count, switch_state, pressed_ms, input ready);
	modport sink (input valid, count_delta, raw_count, switch_state, pressed_ms, output ready);
endinterface

// filter window write channel
interface rewb_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/rewb_in_reg.sv =====
module rewb_in_reg
	import rewb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rewb_cmd_if.sink     cmd,
	input  logic         advance,
	output logic         valid_s1,
	output item_t        item_s1
);

	logic take;

	// room when empty or when the held request moves on this cycle
	assign cmd.ready = !valid_s1 || advance;
	assign take      = cmd.valid && cmd.ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.operation    <= op_t'(cmd.operation);
			item_s1.phase_a      <= cmd.phase_a;
			item_s1.phase_b      <= cmd.phase_b;
			item_s1.switch_level <= cmd.switch_level;
		end
	end

endmodule

// ===== hdl/rewb_engine.sv =====
`include "assert_macros.svh"

module rewb_engine
	import rewb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rewb_cfg_if.sink   cfg,
	input  pipe_ctl_t  ctl,
	input  item_t      item_s1,
	output result_t    result
);

	logic [WIN_W-1:0] window_q;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] last_q, last_d;
	logic [CNT_W-1:0] stamp_q, stamp_d;
	logic [CNT_W-1:0] now_q, now_d;
	logic [CNT_W-1:0] start_q, start_d;
	logic             prev_a_q, prev_a_d;
	logic             run_q, run_d;
	stage_t           stage_q, stage_d;
	sw_state_t        bstate_q, bstate_d;
	sw_state_t        shown;
	logic [CNT_W-1:0] delta;
	logic [CNT_W-1:0] elapsed;
	logic             win_ok;
	logic             moved;
	logic             fire;

	assign fire      = ctl.valid_s1 && ctl.advance;
	assign cfg.ready = 1'b1;

	// filter window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= FILTER_RESET_MS;
		end else if (cfg.valid) begin
			window_q <= cfg.data;
		end
	end

	// rate limit check for filtered reads
	assign elapsed = now_q - stamp_q;
	assign win_ok  = elapsed >= {{(CNT_W-WIN_W){1'b0}}, window_q};
	assign moved   = pos_q != last_q;

	// next state for the request in the input register
	always_comb begin
		pos_d    = pos_q;
		last_d   = last_q;
		stamp_d  = stamp_q;
		now_d    = now_q;
		start_d  = start_q;
		prev_a_d = prev_a_q;
		run_d    = run_q;
		stage_d  = stage_q;
		bstate_d = bstate_q;
		delta    = '0;
		unique case (item_s1.operation)
			OP_SAMPLE: begin
				// quadrature step on a phase a change
				if (item_s1.phase_a != prev_a_q) begin
					if (item_s1.phase_b != item_s1.phase_a) begin
						pos_d = pos_q + 32'd1;
					end else begin
						pos_d = pos_q - 32'd1;
					end
					prev_a_d = item_s1.phase_a;
				end
				// press/release machine, switch is active low
				unique case (stage_q)
					STG_WAIT_PRESS: begin
						if (!item_s1.switch_level) begin
							bstate_d = SW_JUST_PRESSED;
							stage_d  = STG_WAIT_RELEASE;
						end
					end
					STG_WAIT_RELEASE: begin
						if (!run_q) begin
							run_d   = 1'b1;
							start_d = now_q;
						end
						if (item_s1.switch_level) begin
							bstate_d = SW_JUST_RELEASED;
							run_d    = 1'b0;
							stage_d  = STG_WAIT_PRESS;
						end
					end
					default: begin
						stage_d = STG_WAIT_PRESS;
					end
				endcase
			end
			OP_TICK: begin
				now_d = now_q + 32'd1;
			end
			OP_FREAD: begin
				// accept or drop the pending counts
				if (moved && win_ok) begin
					stamp_d = now_q;
					delta   = pos_q - last_q;
					last_d  = pos_q;
				end else begin
					pos_d = last_q;
				end
			end
			OP_SREAD: begin
				priority if (bstate_q == SW_JUST_RELEASED) begin
					bstate_d = SW_RELEASED;
				end else if (bstate_q == SW_JUST_PRESSED) begin
					bstate_d = SW_PRESSED;
				end
			end
			default: begin
			end
		endcase
		// a switch read reports the state before the edge is cleared
		shown = (item_s1.operation == OP_SREAD) ? bstate_q : bstate_d;
	end

	// result for the result register
	assign result.count_delta  = $signed(delta);
	assign result.raw_count    = $signed(pos_d);
	assign result.switch_state = shown;
	assign result.pressed_ms   = run_d ? (now_d - start_d) : '0;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			last_q   <= '0;
			stamp_q  <= '0;
			now_q    <= '0;
			start_q  <= '0;
			prev_a_q <= 1'b0;
			run_q    <= 1'b0;
			stage_q  <= STG_WAIT_PRESS;
			bstate_q <= SW_RELEASED;
		end else if (fire) begin
			pos_q    <= pos_d;
			last_q   <= last_d;
			stamp_q  <= stamp_d;
			now_q    <= now_d;
			start_q  <= start_d;
			prev_a_q <= prev_a_d;
			run_q    <= run_d;
			stage_q  <= stage_d;
			bstate_q <= bstate_d;
		end
	end

	// press timer only runs while waiting for release
	`REWB_ASSERT_NOW(a_timer_stage, run_q, stage_q == STG_WAIT_RELEASE, "timer running outside press")
	// a filtered read always leaves no pending counts
	`REWB_ASSERT_NEXT(a_fread_sync, fire && item_s1.operation == OP_FREAD, pos_q == last_q, "pending counts after filtered read")
	// a tick advances the clock by one
	`REWB_ASSERT_NEXT(a_tick_step, fire && item_s1.operation == OP_TICK, now_q == $past(now_q) + 32'd1, "tick did not advance time")

endmodule

// ===== hdl/rewb_out_reg.sv =====
module rewb_out_reg
	import rewb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rewb_rsp_if.source  rsp,
	input  logic        load,
	input  result_t     result,
	output logic        room
);

	logic    valid_q;
	result_t data_q;

	// free when empty or being taken this cycle
	assign room = !valid_q || rsp.ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.count_delta  = data_q.count_delta;
	assign rsp.raw_count    = data_q.raw_count;
	assign rsp.switch_state = data_q.switch_state;
	assign rsp.pressed_ms   = data_q.pressed_ms;

endmodule

// ===== hdl/rotary_encoder_with_button.sv =====
// Rotary knob and push switch interface. Each request (pin sample, millisecond tick,
// filtered count read or switch read) gives exactly one result. A request is taken
// every cycle when the result side keeps up; it passes an input register, one pass
// of state update logic and a result register; its result is offered once it leaves the
// input register. The 32-bit count and time updates in that single pass set the clock
// limit. The filter window register resets to 250 ms and may be written while idle.
module rotary_encoder_with_button
	import rewb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rewb_cmd_if.sink    cmd,
	rewb_rsp_if.source  rsp,
	rewb_cfg_if.sink    cfg
);

	pipe_ctl_t ctl;
	item_t     item_s1;
	result_t   result;
	logic      room;

	// held request moves on when the result register has room
	assign ctl.advance = ctl.valid_s1 && room;

	rewb_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (ctl.advance),
		.valid_s1 (ctl.valid_s1),
		.item_s1  (item_s1)
	);

	rewb_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.ctl     (ctl),
		.item_s1 (item_s1),
		.result  (result)
	);

	rewb_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.rsp    (rsp),
		.load   (ctl.advance),
		.result (result),
		.room   (room)
	);

endmodule
